// File: hw/rtl/lru_kv_pkg.sv
package lru_kv_pkg;

    // Payload widths, fixed by the request and response formats.
    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;

    // Capacity register.
    localparam int CAP_REG_BITS  = 5;
    localparam logic [CAP_REG_BITS-1:0] CAP_RESET = 5'd16;

    // Default number of entries.
    localparam int CAPACITY_DEF  = 16;

    // Slot field in the rank table command, wide enough for the largest store.
    localparam int SLOT_BITS     = 8;

    // Command codes.
    localparam logic CMD_GET     = 1'b0;
    localparam logic CMD_PUT     = 1'b1;

    // Request fields.
    typedef struct packed {
        logic                          cmd;
        logic signed [KEY_BITS-1:0]    key;
        logic signed [VALUE_BITS-1:0]  data_in;
    } t_req;

    // Response fields.
    typedef struct packed {
        logic                          found;
        logic signed [VALUE_BITS-1:0]  read_value;
    } t_rsp;

    // Command to the rank table: promote an entry, or insert into a slot.
    typedef struct packed {
        logic                  en;
        logic                  ins;
        logic [SLOT_BITS-1:0]  slot;
    } t_rank_op;

endpackage

// File: hw/rtl/lru_kv_rank.sv
module lru_kv_rank #(
    parameter int  CAPACITY = lru_kv_pkg::CAPACITY_DEF,
    localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int OW       = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lru_kv_pkg::t_rank_op i_op,
    input  logic [IW-1:0]        i_idx,
    output logic                 o_valid,
    output logic [IW-1:0]        o_rank,
    output logic [OW-1:0]        o_occ
);
    import lru_kv_pkg::*;

    logic [CAPACITY-1:0] r_valid;
    logic [IW-1:0]       r_rank [CAPACITY];
    logic [OW-1:0]       r_occ;
    logic [IW-1:0]       w_sel;
    logic [IW-1:0]       w_sel_rank;

    // Slot addressed by the command and its present rank.
    assign w_sel      = i_op.slot[IW-1:0];
    assign w_sel_rank = r_rank[w_sel];

    // Lookup port used by the scan.
    assign o_valid = r_valid[i_idx];
    assign o_rank  = r_rank[i_idx];
    assign o_occ   = r_occ;

    // Rank update: newer ones (all on insert) age in parallel, chosen one gets zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_op.en) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (i_op.ins) begin
                    if (r_valid[i] && (IW'(i) != w_sel)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end else if (r_valid[i] && (r_rank[i] < w_sel_rank)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            r_rank[w_sel] <= '0;
            if (i_op.ins) begin
                r_valid[w_sel] <= 1'b1;
                // A free slot grows the store; an evicted slot is reused.
                if (!r_valid[w_sel]) begin
                    r_occ <= r_occ + 1'b1;
                end
            end
        end
    end

    // The fill count always matches the number of live entries.
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy does not match valid entries");

    // The fill count never exceeds the store.
    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= CAPACITY)
        else $error("occupancy above capacity");

endmodule

// File: hw/rtl/lru_key_value_cache.sv
// Channel   | Direction | Transfer condition          | Payload
// ----------+-----------+-----------------------------+------------------------
// request   | in        | start high, busy low        | i_req  (cmd, key, data_in)
// response  | out       | o_strobe high (one cycle)   | o_rsp  (found, read_value)
// config    | in        | i_cfg_valid and o_cfg_ready | i_cfg_data (capacity_in_use)
//
// Each request keeps busy high through a scan of every entry, one entry per cycle
// through the single read port of the key/value memory, then a last compare state
// and an update state.
// A get answers with o_strobe in the same cycle that busy falls; a put gives no response.
// Reset is synchronous and active low; the store starts empty, no clearing pass.
// The receiver cannot stall the response; the config port is always ready.
module lru_key_value_cache #(
    parameter int CAPACITY = lru_kv_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  lru_kv_pkg::t_req                    i_req,
    output logic                                busy,
    output logic                                o_strobe,
    output lru_kv_pkg::t_rsp                    o_rsp,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lru_kv_pkg::CAP_REG_BITS-1:0] i_cfg_data
);
    import lru_kv_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = (OW > CAP_REG_BITS) ? OW : CAP_REG_BITS;
    localparam int WW = KEY_BITS + VALUE_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]              r_state;
    logic [CAP_REG_BITS-1:0] r_cap;
    logic                    r_cmd;
    logic [KEY_BITS-1:0]     r_key;
    logic [VALUE_BITS-1:0]   r_data;
    logic [IW-1:0]           r_addr;
    logic [IW-1:0]           r_cmp_idx;
    logic                    r_cmp_vld;
    logic [WW-1:0]           r_rd_data;
    logic                    r_hit;
    logic [IW-1:0]           r_hit_idx;
    logic [VALUE_BITS-1:0]   r_hit_val;
    logic                    r_have_free;
    logic [IW-1:0]           r_free_idx;
    logic                    r_have_vic;
    logic [IW-1:0]           r_vic_idx;
    logic [IW-1:0]           r_vic_rank;
    logic                    r_strobe;
    t_rsp                    r_rsp;

    logic [WW-1:0]           mem [CAPACITY];

    logic [CW-1:0]           w_eff_cap;
    logic                    w_full;
    logic [IW-1:0]           w_slot;
    logic                    w_wr_en;
    logic                    w_valid_q;
    logic [IW-1:0]           w_rank_q;
    logic [OW-1:0]           w_occ;
    t_rank_op                w_op;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // Effective capacity, saturated to one at the bottom and the store size at the top.
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CW'(1);
        end else if (CW'(r_cap) > CW'(CAPACITY)) begin
            w_eff_cap = CW'(CAPACITY);
        end else begin
            w_eff_cap = CW'(r_cap);
        end
    end
    assign w_full = CW'(w_occ) >= w_eff_cap;

    // Sequencer: accept, scan all entries, then update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (start) begin
                        r_cmd   <= i_req.cmd;
                        r_key   <= i_req.key;
                        r_data  <= i_req.data_in;
                        r_addr  <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_addr;
                    if (r_addr == LAST_IDX) begin
                        r_state <= ST_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_LAST: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    r_strobe         <= (r_cmd == CMD_GET);
                    r_rsp.found      <= r_hit;
                    r_rsp.read_value <= r_hit ? r_hit_val : '1;
                    r_state          <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Key and value memory: one registered read per scan cycle, written on a put.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_slot] <= {r_key, r_data};
        end
        r_rd_data <= mem[r_addr];
    end

    // Compare unit: key match, first free slot and oldest live entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == ST_IDLE)) begin
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_have_vic  <= 1'b0;
        end else if (r_cmp_vld) begin
            if (w_valid_q && (r_rd_data[WW-1 -: KEY_BITS] == r_key)) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_val <= r_rd_data[VALUE_BITS-1:0];
            end
            if (!w_valid_q && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_cmp_idx;
            end
            if (w_valid_q && (!r_have_vic || (w_rank_q > r_vic_rank))) begin
                r_have_vic <= 1'b1;
                r_vic_idx  <= r_cmp_idx;
                r_vic_rank <= w_rank_q;
            end
        end
    end

    // Slot for the update: the hit entry, else the oldest when full, else a free one.
    always_comb begin
        if (r_hit) begin
            w_slot = r_hit_idx;
        end else if (w_full) begin
            w_slot = r_vic_idx;
        end else begin
            w_slot = r_free_idx;
        end
    end

    assign w_wr_en  = (r_state == ST_UPDATE) && (r_cmd == CMD_PUT);
    assign w_op.en   = (r_state == ST_UPDATE) && (r_hit || (r_cmd == CMD_PUT));
    assign w_op.ins  = !r_hit;
    assign w_op.slot = SLOT_BITS'(w_slot);

    // Valid bits, recency ranks and fill count.
    lru_kv_rank #(
        .CAPACITY (CAPACITY)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_idx   (r_cmp_idx),
        .o_valid (w_valid_q),
        .o_rank  (w_rank_q),
        .o_occ   (w_occ)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // An accepted request occupies the block in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // Responses are never back to back.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("response strobe held for two cycles");

    // Only a get produces a response, and only once the scan is over.
    a_strobe_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((r_cmd == CMD_GET) && (r_state == ST_IDLE)))
        else $error("response strobe outside a finished get");

endmodule

// File: bench/lru_key_value_cache_tb.sv
module lru_key_value_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_kv_pkg::*;

    localparam int SLOTS        = CAPACITY_DEF;
    localparam int DRAIN_CYCLES = SLOTS + 8;
    localparam int PHASE_ITEMS  = 73;
    localparam int STALL_LIMIT  = 2000;
    localparam int POOL_DEPTH   = 24;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    t_req                    i_req       = '0;
    logic                    busy;
    logic                    o_strobe;
    t_rsp                    o_rsp;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CAP_REG_BITS-1:0] i_cfg_data  = '0;

    lru_key_value_cache #(
        .CAPACITY(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the store: keys, values, occupancy and recency order.
    logic [KEY_BITS-1:0]     slot_key   [SLOTS];
    logic [VALUE_BITS-1:0]   slot_value [SLOTS];
    bit                      slot_used  [SLOTS];
    int unsigned             slot_age   [SLOTS];
    int unsigned             fill_count = 0;
    logic [CAP_REG_BITS-1:0] cap_reg    = CAP_RESET;

    t_req queued_requests [$];
    t_rsp get_answers [$];

    int  requests_queued   = 0;
    int  requests_taken    = 0;
    int  gets_seen         = 0;
    int  hits_seen         = 0;
    int  evictions         = 0;
    int  responses_checked = 0;
    int  mismatch_count    = 0;
    int  cap_writes        = 0;
    int  hold_off          = 0;
    int  quiet_cycles      = 0;
    bit  steady_flow       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The register saturates to the range of slots the store really has.
    function automatic int unsigned usable_slots();
        int unsigned c;
        c = cap_reg;
        if (c < 1) c = 1;
        if (c > SLOTS) c = SLOTS;
        return c;
    endfunction

    // Age every entry that was newer than slot s, then make s the newest.
    function automatic void make_newest(int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    // Apply one request to the shadow store and queue the answer of a get.
    function automatic void cache_access(t_req r);
        int   s;
        t_rsp answer;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && slot_used[i] && slot_key[i] == r.key) s = i;
        if (r.cmd == CMD_GET) begin
            gets_seen++;
            if (s >= 0) begin
                make_newest(s);
                answer.found      = 1'b1;
                answer.read_value = slot_value[s];
                hits_seen++;
            end else begin
                answer.found      = 1'b0;
                answer.read_value = '1;
            end
            get_answers.push_back(answer);
        end else if (s >= 0) begin
            make_newest(s);
            slot_value[s] = r.data_in;
        end else begin
            // Full (or over-full after a lower setting): reuse the oldest slot.
            if (fill_count >= usable_slots()) begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && (s < 0 || slot_age[i] > slot_age[s])) s = i;
                slot_used[s] = 1'b0;
                evictions++;
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !slot_used[i]) s = i;
                fill_count++;
            end
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i]) slot_age[i]++;
            slot_key[s]   = r.key;
            slot_value[s] = r.data_in;
            slot_used[s]  = 1'b1;
            slot_age[s]   = 0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch at %0t: %0s, expected %h, got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Mostly short pauses, now and then a long one; none at all in steady phases.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 40) return 0;
        if (roll < 80) return $urandom_range(1, 4);
        if (roll < 96) return $urandom_range(5, 24);
        return $urandom_range(25, 80);
    endfunction

    // Request driver: a request stays up until it is taken, then a gap of random length, possibly none, follows.
    always @(posedge i_clk) begin : request_driver
        bit taken;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) begin
                cache_access(i_req);
                requests_taken++;
                hold_off = draw_gap();
            end
            if (!start || taken) begin
                if (hold_off > 0) begin
                    hold_off--;
                    start <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    i_req <= queued_requests.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Response monitor: every strobe must match the oldest outstanding get.
    always @(posedge i_clk) begin : response_monitor
        t_rsp want;
        if (i_rst_n && o_strobe) begin
            responses_checked++;
            if (get_answers.size() == 0) begin
                report_mismatch("response with no get outstanding", '0, o_rsp.read_value);
            end else begin
                want = get_answers.pop_front();
                if (o_rsp.found !== want.found)
                    report_mismatch("found", want.found, o_rsp.found);
                if (o_rsp.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, o_rsp.read_value);
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin : stall_watchdog
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL lru_key_value_cache");
            $finish;
        end
    end

    task automatic queue_request(logic cmd, logic [31:0] key, logic [31:0] value);
        t_req r;
        r.cmd     = cmd;
        r.key     = key;
        r.data_in = value;
        queued_requests.push_back(r);
        requests_queued++;
    endtask

    // Wait for every request to be taken and answered, then let the last put finish.
    task automatic wait_until_drained();
        while (requests_taken != requests_queued || get_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_REG_BITS-1:0] setting);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= setting;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_reg = setting;
        cap_writes++;
    endtask

    initial begin : stimulus
        t_req                    r;
        logic [KEY_BITS-1:0]     key_pool [POOL_DEPTH];
        int                      pool_size;
        logic [CAP_REG_BITS-1:0] cap_plan [10];

        // Extremes first, then settings that shrink below and grow above occupancy.
        cap_plan = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd2, 5'd12, 5'd16, 5'd5};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity: empty store, extreme keys and
        // values, a stored value of all ones, overwrite, then fill to eviction.
        queue_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        queue_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        queue_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_request(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
        queue_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_request(CMD_GET, 32'h8000_0000, 32'hffff_ffff);
        queue_request(CMD_PUT, 32'h7fff_ffff, 32'h1234_5678);
        queue_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_request(CMD_GET, 32'h0001_2345, 32'h0000_0000);
        for (int k = 0; k < 14; k++)
            queue_request(CMD_PUT, 32'd100 + k, ~k);
        queue_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        wait_until_drained();

        // Random phases: keys mostly from a pool a little larger than the
        // capacity in use, so that hits, overwrites and evictions all occur.
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int p = 0; p < 10; p++) begin
            write_capacity(cap_plan[p]);
            steady_flow = ($urandom_range(0, 3) == 0);
            pool_size   = usable_slots() + $urandom_range(0, 4);
            foreach (key_pool[i])
                if ($urandom_range(0, 1) == 1) key_pool[i] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r.cmd = ($urandom_range(0, 99) < 50) ? CMD_GET : CMD_PUT;
                if ($urandom_range(0, 99) < 85)
                    r.key = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    r.key = $urandom;
                r.data_in = $urandom;
                queue_request(r.cmd, r.key, r.data_in);
            end
            wait_until_drained();
        end

        $display("Run covered %0d requests (%0d gets, %0d hits), %0d evictions, %0d settings.",
                 requests_taken, gets_seen, hits_seen, evictions, cap_writes);
        $display("%0d responses checked, %0d mismatches.", responses_checked, mismatch_count);
        if (mismatch_count == 0 && get_answers.size() == 0) begin
            $display("PASS lru_key_value_cache");
        end else begin
            $display("FAIL lru_key_value_cache");
        end
        $finish;
    end

endmodule
